// ----- rtl/core/wss_pkg.sv -----
package wss_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = 6;
  localparam int THR_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 22;
  localparam int SQSUM_W    = 36;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int NN_W       = 2 * LEN_W - 1;
  localparam int TT_W       = 2 * THR_W;
  localparam int NQ_W       = LEN_W + SQSUM_W;
  localparam int LIM_W      = NN_W + TT_W;
  localparam int SPREAD_W   = 2 * SUM_W;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0] WINDOW_RESET    = LEN_W'(5);
  localparam logic [LEN_W-1:0] WINDOW_MAX      = LEN_W'(MAX_WINDOW);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(16);

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH       = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_STABILITY_THRESHOLD = 1'b1;

  typedef struct packed {
    logic                wr_en;
    logic                clear;
    logic [IDX_W-1:0]    addr;
    logic [SAMPLE_W-1:0] wdata;
  } ring_req_t;

endpackage

// ----- rtl/core/wss_ring.sv -----
module wss_ring (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wss_pkg::ring_req_t                  req,
  output logic signed [wss_pkg::SAMPLE_W-1:0] old_sample
);

  logic [wss_pkg::SAMPLE_W-1:0]   mem [wss_pkg::MAX_WINDOW];
  logic [wss_pkg::MAX_WINDOW-1:0] valid_r;
  logic [wss_pkg::SAMPLE_W-1:0]   rd_data_r;
  logic                           rd_valid_r;

  // read-first: the old entry comes back while the new sample goes in
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
      rd_data_r     <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else if (req.clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
      rd_valid_r        <= valid_r[req.addr];
    end
  end

  // entries never written since the last clear read as zero samples
  assign old_sample = rd_valid_r ? $signed(rd_data_r) : '0;

endmodule

// ----- rtl/core/window_stddev_stability_detector.sv -----
// channel  dir  tdata                        tuser  tlast
// in_      in   [15:0] temperature_sample    -      -
// out_     out  [0] stable, [7:1] zero       -      -
// cfg_     in   index 0 window_length, 1 stability_threshold (write only)
//
// each sample passes through the steps ring read-modify-write, sum update,
// square-sum update, products (N*Q, S*S, N*N*T*T) and compare; the sequencer
// takes no new sample until it is back in its idle step
// the next sample is taken while a result still waits in the output register
// a stalled output holds the sequencer in its compare step
// reset (rst_n low, synchronous) clears the ring valid bits at once, the sums,
// the index and the registers to their defaults; no clearing pass
module window_stddev_stability_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] temperature_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] stable, [7:1] zero
  input  logic                               cfg_wen,
  input  logic [wss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQ,
    ST_MUL,
    ST_CMP
  } state_t;

  state_t                                state_r;
  logic [wss_pkg::LEN_W-1:0]             wl_r;
  logic [wss_pkg::THR_W-1:0]             thr_r;
  logic [wss_pkg::IDX_W-1:0]             wr_idx_r;
  logic [wss_pkg::IDX_W-1:0]             wr_idx_nxt;
  logic signed [wss_pkg::SUM_W-1:0]      sum_r;
  logic signed [wss_pkg::SUM_W-1:0]      sum_nxt;
  logic [wss_pkg::SQSUM_W-1:0]           sqsum_r;
  logic [wss_pkg::SQSUM_W-1:0]           sqsum_nxt;
  logic                                  out_valid_r;
  logic                                  out_stable_r;

  logic signed [wss_pkg::SAMPLE_W-1:0]   x_r;
  logic [wss_pkg::SQ_W-1:0]              xsq_r;
  logic [wss_pkg::SQ_W-1:0]              oldsq_r;
  logic [wss_pkg::NN_W-1:0]              nn_r;
  logic [wss_pkg::TT_W-1:0]              tt_r;
  logic [wss_pkg::NQ_W-1:0]              nq_r;
  logic signed [wss_pkg::SPREAD_W-1:0]   ss_r;
  logic [wss_pkg::LIM_W-1:0]             lim_r;

  logic                                  accept;
  logic                                  load_out;
  logic signed [wss_pkg::SAMPLE_W-1:0]   x_in;
  logic signed [wss_pkg::SQ_W-1:0]       xsq_full;
  logic signed [wss_pkg::SAMPLE_W-1:0]   old_sample;
  logic signed [wss_pkg::SQ_W-1:0]       oldsq_full;
  logic [wss_pkg::LEN_W-1:0]             cfg_len;
  logic signed [wss_pkg::SPREAD_W-1:0]   spread;
  logic                                  stable_nxt;
  wss_pkg::ring_req_t                    ring_req;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign load_out   = (state_r == ST_CMP) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_stable_r};

  assign x_in       = $signed(in_tdata);
  assign xsq_full   = x_in * x_in;
  assign oldsq_full = old_sample * old_sample;

  // saturate to the ring depth
  assign cfg_len = (cfg_wdata[wss_pkg::LEN_W-1:0] > wss_pkg::WINDOW_MAX) ?
                   wss_pkg::WINDOW_MAX : cfg_wdata[wss_pkg::LEN_W-1:0];

  assign wr_idx_nxt = ({1'b0, wr_idx_r} + wss_pkg::LEN_W'(1) >= wl_r) ?
                      '0 : wr_idx_r + wss_pkg::IDX_W'(1);

  assign sum_nxt = sum_r
                 + {{(wss_pkg::SUM_W-wss_pkg::SAMPLE_W){x_r[wss_pkg::SAMPLE_W-1]}}, x_r}
                 - {{(wss_pkg::SUM_W-wss_pkg::SAMPLE_W){old_sample[wss_pkg::SAMPLE_W-1]}},
                    old_sample};
  assign sqsum_nxt = sqsum_r + wss_pkg::SQSUM_W'(xsq_r) - wss_pkg::SQSUM_W'(oldsq_r);

  assign spread     = $signed({{(wss_pkg::SPREAD_W-wss_pkg::NQ_W){1'b0}}, nq_r}) - ss_r;
  assign stable_nxt = spread < $signed({{(wss_pkg::SPREAD_W-wss_pkg::LIM_W){1'b0}}, lim_r});

  wire new_len = cfg_wen && (cfg_addr == wss_pkg::REG_WINDOW_LENGTH) &&
                 (cfg_len != '0) && (cfg_len != wl_r);

  always_comb begin
    ring_req.wr_en = accept;
    ring_req.clear = new_len;
    ring_req.addr  = wr_idx_r;
    ring_req.wdata = in_tdata;
  end

  wss_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ring_req),
    .old_sample (old_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wl_r         <= wss_pkg::WINDOW_RESET;
      thr_r        <= wss_pkg::THRESHOLD_RESET;
      wr_idx_r     <= '0;
      sum_r        <= '0;
      sqsum_r      <= '0;
      out_valid_r  <= 1'b0;
      out_stable_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r  <= 1'b1;
        out_stable_r <= stable_nxt;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (new_len) begin
        wl_r     <= cfg_len;
        wr_idx_r <= '0;
        sum_r    <= '0;
        sqsum_r  <= '0;
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            if (accept) begin
              wr_idx_r <= wr_idx_nxt;
              state_r  <= ST_SUM;
            end
          end
          ST_SUM: begin
            sum_r   <= sum_nxt;
            state_r <= ST_SQ;
          end
          ST_SQ: begin
            sqsum_r <= sqsum_nxt;
            state_r <= ST_MUL;
          end
          ST_MUL: begin
            state_r <= ST_CMP;
          end
          ST_CMP: begin
            if (load_out) begin
              state_r <= ST_IDLE;
            end
          end
          default: state_r <= ST_IDLE;
        endcase
      end
      if (cfg_wen && (cfg_addr == wss_pkg::REG_STABILITY_THRESHOLD)) begin
        thr_r <= cfg_wdata[wss_pkg::THR_W-1:0];
      end
    end
  end

  // datapath registers, loaded in the accept, sum and multiply steps
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= x_in;
      xsq_r <= $unsigned(xsq_full);
    end
    if (state_r == ST_SUM) begin
      oldsq_r <= $unsigned(oldsq_full);
      nn_r    <= wss_pkg::NN_W'(wl_r) * wss_pkg::NN_W'(wl_r);
      tt_r    <= thr_r * thr_r;
    end
    if (state_r == ST_MUL) begin
      nq_r  <= wl_r * sqsum_r;
      ss_r  <= sum_r * sum_r;
      lim_r <= nn_r * tt_r;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SUM))
    else $error("accepted sample did not start the update");

  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_idx_r} < wl_r) && (wl_r != '0) && (wl_r <= wss_pkg::WINDOW_MAX))
    else $error("write index or window length out of range");

  a_out_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_CMP))
    else $error("result appeared outside the compare step");

  a_zero_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (thr_r == '0)) |=> !out_stable_r)
    else $error("zero threshold reported stable");

endmodule

// ----- bench/tb.sv -----
module tb;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP       = 12;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [15:0]                    in_tdata   = '0;  // [15:0] temperature_sample
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;        // [0] stable, [7:1] zero
  logic                           cfg_wen    = 1'b0;
  logic [wss_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // window predictor
  logic signed [wss_pkg::SAMPLE_W-1:0] ring_model [wss_pkg::MAX_WINDOW];
  int     ring_pos;
  longint win_sum, win_sq_sum, win_len, stab_thr;

  logic stable_expect_q [$];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   stable_seen  = 0;
  int   samples_sent = 0;
  int   reg_writes   = 0;
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   hold_left    = 0;
  int   cycle_count  = 0;
  logic hold_token   = 1'b0;
  logic hold_seen    = 1'b0;

  window_stddev_stability_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("window_stddev_stability_detector test failed");
      $finish;
    end
  end

  function automatic void clear_ring_model();
    foreach (ring_model[i]) ring_model[i] = '0;
    ring_pos   = 0;
    win_sum    = 0;
    win_sq_sum = 0;
  endfunction

  function automatic logic predict_stable(input logic signed [wss_pkg::SAMPLE_W-1:0] smp);
    longint x, old, spread, limit;
    x   = smp;
    old = ring_model[ring_pos];
    win_sum    += x - old;
    win_sq_sum += x * x - old * old;
    ring_model[ring_pos] = smp;
    ring_pos = (ring_pos + 1 >= win_len) ? 0 : ring_pos + 1;
    // N*Q - S^2 < N^2*T^2 stands in for sqrt(var) < T
    spread = win_len * win_sq_sum - win_sum * win_sum;
    limit  = win_len * win_len * stab_thr * stab_thr;
    return spread < limit;
  endfunction

  function automatic void model_reg_write(input logic [wss_pkg::CFG_ADDR_W-1:0] idx,
                                          input logic [wss_pkg::CFG_DATA_W-1:0] val);
    longint n;
    n = val[wss_pkg::LEN_W-1:0];
    if (idx == wss_pkg::REG_WINDOW_LENGTH) begin
      if (n > wss_pkg::MAX_WINDOW) n = wss_pkg::MAX_WINDOW;
      // zero is dropped, the current length keeps the ring
      if (n != 0 && n != win_len) begin
        win_len = n;
        clear_ring_model();
      end
    end else if (idx == wss_pkg::REG_STABILITY_THRESHOLD) begin
      stab_thr = val[wss_pkg::THR_W-1:0];
    end
  endfunction

  function automatic void note_failure(input string what, input int exp_v,
                                       input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("cycle %0d: %s: expected stable=%0d, got tdata=0x%02h",
               cycle_count, what, exp_v, got);
  endfunction

  // result side: random or held-off ready, check against oldest expectation
  always @(posedge clk) begin
    logic exp_stable;
    if (out_tvalid && out_tready) begin
      results_seen++;
      if (stable_expect_q.size() == 0) begin
        note_failure("result with no request pending", -1, out_tdata);
      end else begin
        exp_stable = stable_expect_q.pop_front();
        if (exp_stable) stable_seen++;
        if (out_tdata[0] !== exp_stable || out_tdata[7:1] !== 7'd0)
          note_failure("stable flag mismatch", exp_stable, out_tdata);
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_sample(input logic [wss_pkg::SAMPLE_W-1:0] smp);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    // hold the request until the block takes it
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stable_expect_q.push_back(predict_stable(smp));
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (stable_expect_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [wss_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [wss_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    model_reg_write(idx, val);
    reg_writes++;
  endtask

  // default window of five and threshold of 16 after reset
  task automatic test_power_on_window();
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
  endtask

  task automatic test_window_length_writes();
    write_reg(wss_pkg::REG_WINDOW_LENGTH, 16'd0);
    send_sample(16'd3);
    write_reg(wss_pkg::REG_WINDOW_LENGTH, wss_pkg::CFG_DATA_W'(wss_pkg::WINDOW_RESET));
    send_sample(16'd3);
    write_reg(wss_pkg::REG_WINDOW_LENGTH, 16'd40);
    send_sample(16'h8000);
    // upper bits beyond the length field are dropped
    write_reg(wss_pkg::REG_WINDOW_LENGTH, 16'hFFC1);
    send_sample(16'd1234);
    send_sample(16'hFB2E);
  endtask

  task automatic test_threshold_limits();
    write_reg(wss_pkg::REG_STABILITY_THRESHOLD, 16'd0);
    send_sample(16'd5);
    send_sample(16'd5);
    write_reg(wss_pkg::REG_WINDOW_LENGTH, 16'd2);
    write_reg(wss_pkg::REG_STABILITY_THRESHOLD, 16'hFFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    write_reg(wss_pkg::REG_WINDOW_LENGTH, 16'd3);
    write_reg(wss_pkg::REG_STABILITY_THRESHOLD, 16'd1);
    send_sample(16'd7);
    send_sample(16'd7);
    send_sample(16'd7);
    send_sample(16'd8);
    write_reg(wss_pkg::REG_STABILITY_THRESHOLD,
              wss_pkg::CFG_DATA_W'(wss_pkg::THRESHOLD_RESET));
  endtask

  task automatic test_random_traffic();
    int seg, k, mode, spread, v;
    logic signed [wss_pkg::SAMPLE_W-1:0] base;
    logic [wss_pkg::CFG_DATA_W-1:0] len_val, thr_val;
    for (seg = 0; seg < 20; seg++) begin
      tx_idle_pct = (seg < 7) ? 34 : (seg < 14) ? 46 : 0;
      rx_idle_pct = (seg < 7) ? 46 : (seg < 14) ? 34 : 0;
      case ($urandom_range(5))
        0:       len_val = 16'd1;
        1:       len_val = wss_pkg::CFG_DATA_W'(wss_pkg::MAX_WINDOW);
        2:       len_val = wss_pkg::CFG_DATA_W'($urandom_range(16'hFFFF));
        default: len_val = wss_pkg::CFG_DATA_W'($urandom_range(wss_pkg::MAX_WINDOW, 1));
      endcase
      case ($urandom_range(4))
        0:       thr_val = 16'd0;
        1:       thr_val = 16'hFFFF;
        2:       thr_val = wss_pkg::CFG_DATA_W'($urandom_range(16'hFFFF));
        default: thr_val = wss_pkg::CFG_DATA_W'($urandom_range(64, 1));
      endcase
      write_reg(wss_pkg::REG_WINDOW_LENGTH, len_val);
      write_reg(wss_pkg::REG_STABILITY_THRESHOLD, thr_val);
      mode   = $urandom_range(99);
      base   = wss_pkg::SAMPLE_W'($urandom_range(16'hFFFF));
      // spread near the threshold puts results on both sides of it
      spread = $urandom_range(int'(stab_thr) * 2 + 2);
      for (k = 0; k < 50; k++) begin
        if (mode < 60 && $urandom_range(9) != 0) begin
          v = int'(base) + int'($urandom_range(2 * spread)) - spread;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          send_sample(v[wss_pkg::SAMPLE_W-1:0]);
        end else if (mode < 85 || mode < 60) begin
          send_sample(wss_pkg::SAMPLE_W'($urandom_range(16'hFFFF)));
        end else begin
          case ($urandom_range(3))
            0:       send_sample(16'h7FFF);
            1:       send_sample(16'h8000);
            2:       send_sample(16'hFFFF);
            default: send_sample(16'h0000);
          endcase
        end
      end
    end
  endtask

  // long result stall fills the block, then the sender waits for all results
  task automatic test_stall_and_drain();
    int k, v;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(wss_pkg::REG_WINDOW_LENGTH, 16'd31);
    write_reg(wss_pkg::REG_STABILITY_THRESHOLD, 16'd40);
    hold_token <= ~hold_token;
    for (k = 0; k < 40; k++) begin
      v = int'($urandom_range(200)) - 100;
      send_sample(v[wss_pkg::SAMPLE_W-1:0]);
    end
    wait_drained();
    for (k = 0; k < 10; k++) send_sample(wss_pkg::SAMPLE_W'($urandom_range(16'hFFFF)));
  endtask

  initial begin
    win_len  = wss_pkg::WINDOW_RESET;
    stab_thr = wss_pkg::THRESHOLD_RESET;
    clear_ring_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_power_on_window();
    test_window_length_writes();
    test_threshold_limits();
    test_random_traffic();
    test_stall_and_drain();

    wait_drained();
    repeat (20) @(posedge clk);
    if (stable_expect_q.size() != 0)
      note_failure("results still pending at end", stable_expect_q.size(), 8'h00);

    $display("%0d samples, %0d results checked (%0d stable), %0d register writes",
             samples_sent, results_seen, stable_seen, reg_writes);
    $display("windows 1..%0d incl. ignored and saturated lengths, thresholds 0..65535",
             wss_pkg::MAX_WINDOW);
    if (mismatches == 0) begin
      $display("window_stddev_stability_detector test passed");
    end else begin
      $display("window_stddev_stability_detector test failed");
    end
    $finish;
  end

endmodule
